FILE: sv/ppwl_pkg.sv
// Shared types and constants for the pairwise preference weight learner.
// No dependencies; imported by every file except ppwl_if.
`default_nettype none
package ppwl_pkg;

  localparam int NUM_LANES     = 5;   // factor fields carried per vector
  localparam int FACTOR_COUNT  = 5;   // default number of active lanes
  localparam int QUEUE_DEPTH   = 2;
  localparam int FACTOR_W      = 16;
  localparam int WEIGHT_W      = 32;
  localparam int PROD_W        = WEIGHT_W + FACTOR_W;
  localparam int SCORE_W       = 52;
  localparam int COUNT_W       = 16;
  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 32;

  // item kind codes on the input channel
  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_STEP_SIZE      = 2'd0;
  localparam logic [1:0] REG_MIN_DIFFERENCE = 2'd1;
  localparam logic [1:0] REG_CHOICES_NEEDED = 2'd2;

  localparam logic [15:0] STEP_SIZE_RST      = 16'd3277;
  localparam logic [15:0] MIN_DIFFERENCE_RST = 16'd328;
  localparam logic [15:0] CHOICES_NEEDED_RST = 16'd10;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_RECORD,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic [15:0] step_size;
    logic [15:0] min_difference;
    logic [15:0] choices_needed;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    op_e                                  op;
    logic [NUM_LANES-1:0][FACTOR_W-1:0]   fa;
    logic [NUM_LANES-1:0][FACTOR_W-1:0]   fb;
    logic [NUM_LANES-1:0]                 step_en;
    logic [NUM_LANES-1:0]                 step_up;
  } item_t;

endpackage
`default_nettype wire

FILE: sv/ppwl_if.sv
// Handshake channel interfaces: request channel and result channel.
// Depends on nothing but plain logic types.
`default_nettype none
interface ppwl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] a_rating;
  logic signed [15:0] a_distance;
  logic signed [15:0] a_group;
  logic signed [15:0] a_recency;
  logic signed [15:0] a_viewed;
  logic signed [15:0] b_rating;
  logic signed [15:0] b_distance;
  logic signed [15:0] b_group;
  logic signed [15:0] b_recency;
  logic signed [15:0] b_viewed;

  modport source (output valid, kind, a_rating, a_distance, a_group, a_recency, a_viewed,
                  b_rating, b_distance, b_group, b_recency, b_viewed, input ready);
  modport sink   (input valid, kind, a_rating, a_distance, a_group, a_recency, a_viewed,
                  b_rating, b_distance, b_group, b_recency, b_viewed, output ready);
endinterface

interface ppwl_out_if;
  logic               valid;
  logic               ready;
  logic signed [51:0] score_a;
  logic signed [51:0] score_b;
  logic [51:0]        score_gap;
  logic               trained;
  logic [15:0]        choice_count;

  modport source (output valid, score_a, score_b, score_gap, trained, choice_count,
                  input ready);
  modport sink   (input valid, score_a, score_b, score_gap, trained, choice_count,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/pairwise_preference_weight_learner_core.sv
// Top level of the pairwise preference weight learner: register port, front, queue, back.
// Depends on ppwl_pkg, ppwl_if, ppwl_front, ppwl_queue and ppwl_back.
//
//   channel | dir | handshake       | carries
//   --------+-----+-----------------+--------------------------------------------
//   in_i    | in  | valid/ready     | kind and the A and B factor vectors
//   out_o   | out | valid/ready     | score_a, score_b, score_gap, trained, count
//   APB     | in  | psel/penable    | step_size, min_difference, choices_needed
//
// One request per cycle while the result channel is ready; a result passes through the
// queue entry, multiply stage, sum stage and result register.
// The weight update runs in the same cycle the request leaves the queue, so the
// next request already sees the new weights.
// Reset clears weights, count, queue and pipeline valids at once; no sweep.
// A stalled result freezes the back pipeline; the queue keeps taking requests
// until it holds two.
`default_nettype none
module pairwise_preference_weight_learner_core import ppwl_pkg::*; #(
  parameter int FactorCount = FACTOR_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppwl_in_if.sink               in_i,
  ppwl_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  logic  q_push, q_ready, q_pop, q_valid;
  item_t q_in, q_out;

  // configuration registers: word address, low 16 bits of the data used
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size      <= STEP_SIZE_RST;
      cfg_q.min_difference <= MIN_DIFFERENCE_RST;
      cfg_q.choices_needed <= CHOICES_NEEDED_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_STEP_SIZE:      cfg_q.step_size      <= pwdata[15:0];
        REG_MIN_DIFFERENCE: cfg_q.min_difference <= pwdata[15:0];
        REG_CHOICES_NEEDED: cfg_q.choices_needed <= pwdata[15:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_SIZE:      prdata = {16'd0, cfg_q.step_size};
      REG_MIN_DIFFERENCE: prdata = {16'd0, cfg_q.min_difference};
      REG_CHOICES_NEEDED: prdata = {16'd0, cfg_q.choices_needed};
      default:            prdata = '0;
    endcase
  end

  // front: decode and classify each request
  ppwl_front u_front (
    .in_i      (in_i),
    .cfg_i     (cfg_q),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_item_o  (q_in)
  );

  // two-entry queue lets the front keep taking requests while results stall
  ppwl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  // back: weights, scores and result register
  ppwl_back #(
    .FactorCount (FactorCount)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("request pushed into a full queue");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_wr |=> $stable(cfg_q))
    else $error("configuration changed without a write");

endmodule
`default_nettype wire

FILE: sv/ppwl_front.sv
// Front end: takes requests, decodes kind, finds decisive factors and step sign.
// Depends on ppwl_pkg and ppwl_in_if.
`default_nettype none
module ppwl_front import ppwl_pkg::*; (
  ppwl_in_if.sink  in_i,
  input  cfg_t     cfg_i,
  input  logic     q_ready_i,
  output logic     q_push_o,
  output item_t    q_item_o
);

  logic [NUM_LANES-1:0][FACTOR_W-1:0] fa, fb;
  logic signed [FACTOR_W:0] diff [NUM_LANES];
  logic [FACTOR_W:0]        mag  [NUM_LANES];
  op_e                      op;

  assign fa = {in_i.a_viewed, in_i.a_recency, in_i.a_group, in_i.a_distance, in_i.a_rating};
  assign fb = {in_i.b_viewed, in_i.b_recency, in_i.b_group, in_i.b_distance, in_i.b_rating};

  always_comb begin
    unique case (in_i.kind)
      KIND_RECORD: op = OP_RECORD;
      KIND_CLEAR:  op = OP_CLEAR;
      default:     op = OP_QUERY;   // unused code behaves as a query
    endcase
  end

  always_comb begin
    q_item_o.op = op;
    q_item_o.fa = fa;
    q_item_o.fb = fb;
    for (int i = 0; i < NUM_LANES; i++) begin
      diff[i] = $signed({fa[i][FACTOR_W-1], fa[i]}) - $signed({fb[i][FACTOR_W-1], fb[i]});
      mag[i]  = diff[i][FACTOR_W] ? (FACTOR_W+1)'(-diff[i]) : diff[i];
      q_item_o.step_en[i] = (mag[i] >= {1'b0, cfg_i.min_difference});
      q_item_o.step_up[i] = !diff[i][FACTOR_W] && (diff[i] != '0);
    end
  end

  assign in_i.ready = q_ready_i;
  assign q_push_o   = in_i.valid && q_ready_i;

endmodule
`default_nettype wire

FILE: sv/ppwl_queue.sv
// Short flop queue decoupling the front end from the execution back end.
// Depends on ppwl_pkg.
`default_nettype none
module ppwl_queue import ppwl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  item_t             slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue count beyond depth");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push without pop did not grow queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 || cnt_q == FullCnt |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step with count");

endmodule
`default_nettype wire

FILE: sv/ppwl_back.sv
// Back end: weight store, score pipeline (multiply, sum, gap) and result register.
// Depends on ppwl_pkg and ppwl_out_if.
`default_nettype none
module ppwl_back import ppwl_pkg::*; #(
  parameter int FactorCount = FACTOR_COUNT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  item_t     q_item_i,
  output logic      q_pop_o,
  ppwl_out_if.source out_o
);

  logic adv, take;

  // architectural state
  logic signed [WEIGHT_W-1:0] w_q [FactorCount];
  logic signed [WEIGHT_W-1:0] w_d [FactorCount];
  logic [COUNT_W-1:0]         cnt_q, cnt_d;

  // stage 1: products
  logic                     s1_valid_q;
  logic signed [PROD_W-1:0] s1_pa_q [FactorCount];
  logic signed [PROD_W-1:0] s1_pb_q [FactorCount];
  logic                     s1_trained_q;
  logic [COUNT_W-1:0]       s1_cnt_q;

  // stage 2: scores
  logic                      s2_valid_q;
  logic signed [SCORE_W-1:0] s2_sa_q, s2_sb_q, sa_sum, sb_sum;
  logic                      s2_trained_q;
  logic [COUNT_W-1:0]        s2_cnt_q;

  // result register
  logic                      out_valid_q;
  logic signed [SCORE_W:0]   gap_raw;
  logic [SCORE_W-1:0]        gap_abs;

  assign adv     = !out_valid_q || out_o.ready;
  assign take    = adv && q_valid_i;
  assign q_pop_o = take;

  // weight and count update
  logic signed [WEIGHT_W:0] w_ext [FactorCount];
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < FactorCount; i++) begin
      w_d[i]   = w_q[i];
      w_ext[i] = q_item_i.step_up[i]
               ? $signed({w_q[i][WEIGHT_W-1], w_q[i]}) + $signed({17'd0, cfg_i.step_size})
               : $signed({w_q[i][WEIGHT_W-1], w_q[i]}) - $signed({17'd0, cfg_i.step_size});
    end
    if (take) begin
      case (q_item_i.op)
        OP_RECORD: begin
          for (int i = 0; i < FactorCount; i++) begin
            if (q_item_i.step_en[i]) begin
              if (w_ext[i][WEIGHT_W] != w_ext[i][WEIGHT_W-1])
                w_d[i] = w_ext[i][WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                            : {1'b0, {(WEIGHT_W-1){1'b1}}};
              else
                w_d[i] = w_ext[i][WEIGHT_W-1:0];
            end
          end
          if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
        end
        OP_CLEAR: begin
          for (int i = 0; i < FactorCount; i++) w_d[i] = '0;
          cnt_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FactorCount; i++) w_q[i] <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < FactorCount; i++) w_q[i] <= w_d[i];
      cnt_q <= cnt_d;
      if (adv) begin
        s1_valid_q  <= take;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // products use the weights as they stand before this item
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < FactorCount; i++) begin
        s1_pa_q[i] <= w_q[i] * $signed(q_item_i.fa[i]);
        s1_pb_q[i] <= w_q[i] * $signed(q_item_i.fb[i]);
      end
      s1_trained_q <= (cnt_q >= cfg_i.choices_needed);
      s1_cnt_q     <= cnt_q;
    end
  end

  always_comb begin
    sa_sum = '0;
    sb_sum = '0;
    for (int i = 0; i < FactorCount; i++) begin
      sa_sum = sa_sum + SCORE_W'(s1_pa_q[i]);
      sb_sum = sb_sum + SCORE_W'(s1_pb_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_sa_q      <= sa_sum;
      s2_sb_q      <= sb_sum;
      s2_trained_q <= s1_trained_q;
      s2_cnt_q     <= s1_cnt_q;
    end
  end

  assign gap_raw = $signed({s2_sa_q[SCORE_W-1], s2_sa_q}) - $signed({s2_sb_q[SCORE_W-1], s2_sb_q});
  assign gap_abs = gap_raw[SCORE_W] ? SCORE_W'(-gap_raw) : gap_raw[SCORE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_o.score_a      <= s2_sa_q;
      out_o.score_b      <= s2_sb_q;
      out_o.score_gap    <= gap_abs;
      out_o.trained      <= s2_trained_q;
      out_o.choice_count <= s2_cnt_q;
    end
  end

  assign out_o.valid = out_valid_q;

  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && q_item_i.op == OP_CLEAR |=> cnt_q == '0)
    else $error("clear item left a nonzero count");
  a_query_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && q_item_i.op == OP_QUERY |=> $stable(cnt_q) && $stable(w_q[0]))
    else $error("query item changed state");
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(cnt_q) && $stable(s2_valid_q))
    else $error("back end moved while stalled");

endmodule
`default_nettype wire

FILE: tb/ppwl_rank_checker.sv
// Scoreboard for the pairwise preference weight learner: tracks register writes,
// predicts every result from accepted requests and compares it on the result channel.
// Depends on ppwl_pkg and the channel interfaces in ppwl_if.
`default_nettype none
module ppwl_rank_checker import ppwl_pkg::*; #(
  parameter int Lanes = FACTOR_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppwl_in_if                    req_i,
  ppwl_out_if                   res_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    mismatches_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NUM_LANES-1:0][FACTOR_W-1:0] factor_vec_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_a;
    logic [SCORE_W-1:0] score_b;
    logic [SCORE_W-1:0] score_gap;
    logic               trained;
    logic [COUNT_W-1:0] choice_count;
  } score_rec_t;

  localparam longint WEIGHT_MAX = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
  localparam longint WEIGHT_MIN = -(longint'(1) <<< (WEIGHT_W - 1));

  logic signed [WEIGHT_W-1:0] weight [NUM_LANES];
  logic [COUNT_W-1:0]         choices;
  cfg_t                       cfg;
  score_rec_t                 expected_scores [$];
  int unsigned                results_seen;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns result %0d: %s mismatch, got 0x%0h expected 0x%0h",
             $time, results_seen, what, got, want);
    mismatches_o++;
  endtask

  // scores use the state before the request; record/clear then update it
  task automatic score_and_learn(input logic [1:0] kind, input factor_vec_t fa,
                                 input factor_vec_t fb, output score_rec_t rec);
    longint sum_a, sum_b, gap, w;
    int     diff, mag;
    sum_a = 0;
    sum_b = 0;
    for (int i = 0; i < Lanes; i++) begin
      sum_a += longint'(weight[i]) * longint'($signed(fa[i]));
      sum_b += longint'(weight[i]) * longint'($signed(fb[i]));
    end
    gap = sum_a - sum_b;
    if (gap < 0) gap = -gap;
    rec.score_a      = sum_a[SCORE_W-1:0];
    rec.score_b      = sum_b[SCORE_W-1:0];
    rec.score_gap    = gap[SCORE_W-1:0];
    rec.trained      = (choices >= cfg.choices_needed);
    rec.choice_count = choices;

    if (kind == KIND_RECORD) begin
      for (int i = 0; i < Lanes; i++) begin
        diff = int'($signed(fa[i])) - int'($signed(fb[i]));
        mag  = (diff < 0) ? -diff : diff;
        // a zero gap still counts when min_difference is zero; it steps down
        if (mag >= int'(cfg.min_difference)) begin
          w = longint'(weight[i]);
          if (diff > 0) w += longint'(cfg.step_size);
          else          w -= longint'(cfg.step_size);
          if (w > WEIGHT_MAX) w = WEIGHT_MAX;
          if (w < WEIGHT_MIN) w = WEIGHT_MIN;
          weight[i] = w[WEIGHT_W-1:0];
        end
      end
      if (choices != '1) choices++;
    end else if (kind == KIND_CLEAR) begin
      for (int i = 0; i < NUM_LANES; i++) weight[i] = '0;
      choices = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    score_rec_t  rec, want;
    factor_vec_t fa, fb;
    logic [15:0] want_reg;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LANES; i++) weight[i] = '0;
      choices = '0;
      cfg.step_size      = STEP_SIZE_RST;
      cfg.min_difference = MIN_DIFFERENCE_RST;
      cfg.choices_needed = CHOICES_NEEDED_RST;
      expected_scores.delete();
      results_seen = 0;
      mismatches_o = 0;
      pending_o   <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_STEP_SIZE:      cfg.step_size      = pwdata[15:0];
            REG_MIN_DIFFERENCE: cfg.min_difference = pwdata[15:0];
            REG_CHOICES_NEEDED: cfg.choices_needed = pwdata[15:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_STEP_SIZE:      want_reg = cfg.step_size;
            REG_MIN_DIFFERENCE: want_reg = cfg.min_difference;
            REG_CHOICES_NEEDED: want_reg = cfg.choices_needed;
            default:            want_reg = prdata[15:0];
          endcase
          if (prdata[15:0] !== want_reg)
            report_mismatch("register read", 64'(prdata), 64'(want_reg));
        end
      end

      if (req_i.valid && req_i.ready) begin
        fa = {req_i.a_viewed, req_i.a_recency, req_i.a_group, req_i.a_distance,
              req_i.a_rating};
        fb = {req_i.b_viewed, req_i.b_recency, req_i.b_group, req_i.b_distance,
              req_i.b_rating};
        score_and_learn(req_i.kind, fa, fb, rec);
        expected_scores.push_back(rec);
      end

      if (res_i.valid && res_i.ready) begin
        if (expected_scores.size() == 0) begin
          report_mismatch("unexpected result", 64'(res_i.score_a), 64'(0));
        end else begin
          want = expected_scores.pop_front();
          if (res_i.score_a !== want.score_a)
            report_mismatch("score_a", 64'(res_i.score_a), 64'(want.score_a));
          if (res_i.score_b !== want.score_b)
            report_mismatch("score_b", 64'(res_i.score_b), 64'(want.score_b));
          if (res_i.score_gap !== want.score_gap)
            report_mismatch("score_gap", 64'(res_i.score_gap), 64'(want.score_gap));
          if (res_i.trained !== want.trained)
            report_mismatch("trained", 64'(res_i.trained), 64'(want.trained));
          if (res_i.choice_count !== want.choice_count)
            report_mismatch("choice_count", 64'(res_i.choice_count),
                            64'(want.choice_count));
        end
        results_seen++;
      end

      pending_o <= expected_scores.size();
    end
  end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Top of the pairwise preference weight learner testbench: clock, reset, register
// programming, request stimulus and result back-pressure, plus the final verdict.
// Depends on ppwl_pkg, ppwl_if, the core and ppwl_rank_checker.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ppwl_pkg::*;

  typedef logic [NUM_LANES-1:0][FACTOR_W-1:0] factor_vec_t;

  localparam int          CLK_PERIOD      = 10;
  localparam int          RESET_CYCLES    = 3;
  localparam int          PHASES          = 8;
  localparam int          ITEMS_PER_PHASE = 90;
  // short run of same-direction records at full rate with the largest step
  localparam int          SOAK_RECORDS    = 40;
  localparam int          DRAIN_LIMIT     = 20000;
  // extra idle time after draining, to catch stray results
  localparam int          TAIL_CYCLES     = 12;
  // the unused kind code; the core treats it like a score query
  localparam logic [1:0]  KIND_SPARE      = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    pending;
  bit                    send_gaps_on;
  bit                    result_stalls_on;

  ppwl_in_if  req_if ();
  ppwl_out_if res_if ();

  pairwise_preference_weight_learner_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ppwl_rank_checker rank_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Hard stop, far beyond the slowest legal run (about 800 requests with every
  // gap and stall at its longest).
  initial begin
    #10ms;
    $display("testbench failed");
    $finish;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [FACTOR_W-1:0] corner_factor();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return KIND_RECORD;
    if (roll < 85) return KIND_QUERY;
    if (roll < 93) return KIND_CLEAR;
    return KIND_SPARE;
  endfunction

  // Factor pairs: plain random, gaps right at the decisive threshold,
  // equal factors, and corner values.
  task automatic pick_factors(input logic [15:0] min_gap, output factor_vec_t a,
                              output factor_vec_t b);
    int unsigned style;
    int          offset, sum;
    style = $urandom_range(99);
    for (int i = 0; i < NUM_LANES; i++) begin
      a[i] = 16'($urandom);
      b[i] = 16'($urandom);
      if (style >= 55 && style < 80) begin
        // |a - b| lands on min_difference - 1, min_difference or min_difference + 1
        offset = int'(min_gap) + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) offset = -offset;
        sum = int'($signed(a[i])) + offset;
        b[i] = (sum >= -32768 && sum <= 32767) ? 16'(sum) : a[i];
      end else if (style >= 80 && style < 90) begin
        b[i] = a[i];
      end else if (style >= 90) begin
        a[i] = corner_factor();
        b[i] = corner_factor();
      end
    end
  endtask

  task automatic drive_payload(input logic [1:0] kind, input factor_vec_t a,
                               input factor_vec_t b);
    req_if.kind       <= kind;
    req_if.a_rating   <= a[0];
    req_if.a_distance <= a[1];
    req_if.a_group    <= a[2];
    req_if.a_recency  <= a[3];
    req_if.a_viewed   <= a[4];
    req_if.b_rating   <= b[0];
    req_if.b_distance <= b[1];
    req_if.b_group    <= b[2];
    req_if.b_recency  <= b[3];
    req_if.b_viewed   <= b[4];
  endtask

  // Offer one request, hold it until taken, then maybe leave a gap. When no gap
  // follows, valid stays high and the next call just swaps the payload.
  task automatic push_request(input logic [1:0] kind, input factor_vec_t a,
                              input factor_vec_t b);
    int unsigned gap;
    req_if.valid <= 1'b1;
    drive_payload(kind, a, b);
    do @(posedge clk_i); while (!req_if.ready);
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has come back. Every
  // request yields a result, so an empty scoreboard means the core is idle.
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    req_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending != 0 && guard < DRAIN_LIMIT);
  endtask

  // APB write then read-back of the same register; the checker tracks the write
  // and checks the read data.
  task automatic set_reg(input logic [1:0] index, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side back-pressure: ready runs high for a while, then may drop.
  initial begin : result_backpressure
    int unsigned span;
    forever begin
      res_if.ready <= 1'b1;
      span = $urandom_range(1, 16);
      repeat (span) @(posedge clk_i);
      span = result_stalls_on ? pick_gap() : 0;
      if (span != 0) begin
        res_if.ready <= 1'b0;
        repeat (span) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    factor_vec_t a_vec, b_vec, max_vec, min_vec, a_edge, b_edge;
    logic [15:0] rate, min_gap, min_count;

    max_vec = {NUM_LANES{16'h7FFF}};
    min_vec = {NUM_LANES{16'h8000}};
    // lane 0: gap exactly +min_difference, lane 1: exactly -min_difference,
    // lanes 2/3: one short of it either way, lane 4: full-scale gap
    a_edge  = {16'h7FFF, 16'd0,   16'd327, 16'd0,   16'd328};
    b_edge  = {16'h8000, 16'd327, 16'd0,   16'd328, 16'd0};

    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    req_if.valid     <= 1'b0;
    drive_payload(KIND_QUERY, '0, '0);
    send_gaps_on     = 1'b1;
    result_stalls_on = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, reset register values, weights start at zero ----
    push_request(KIND_QUERY,  max_vec, min_vec);   // all scores zero
    push_request(KIND_RECORD, max_vec, min_vec);   // every weight steps up
    push_request(KIND_QUERY,  max_vec, min_vec);
    push_request(KIND_QUERY,  min_vec, max_vec);
    push_request(KIND_RECORD, '0, '0);             // equal factors, below threshold
    push_request(KIND_RECORD, a_edge, b_edge);     // threshold edges
    push_request(KIND_SPARE,  max_vec, max_vec);   // unused kind, no update
    push_request(KIND_RECORD, min_vec, max_vec);   // every weight steps down
    push_request(KIND_CLEAR,  max_vec, min_vec);   // reports pre-clear state
    push_request(KIND_QUERY,  max_vec, min_vec);

    // zero threshold: equal factors now count and step the weight down
    wait_drained();
    set_reg(REG_MIN_DIFFERENCE, 16'd0);
    pick_factors(16'd0, a_vec, b_vec);
    push_request(KIND_RECORD, a_vec, a_vec);
    push_request(KIND_RECORD, '0, '0);
    push_request(KIND_QUERY, {NUM_LANES{16'hFFFF}}, {NUM_LANES{16'h0001}});
    // enough records to lift the trained flag at the reset choices_needed
    repeat (8) begin
      pick_factors(16'd0, a_vec, b_vec);
      push_request(KIND_RECORD, a_vec, b_vec);
    end
    push_request(KIND_QUERY, max_vec, min_vec);

    // ---- random phases, one register setting each, extremes included ----
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          rate = 16'($urandom); min_gap = 16'($urandom_range(2000));
          min_count = 16'($urandom_range(30));
        end
        1: begin
          rate = 16'd0; min_gap = 16'hFFFF; min_count = 16'd0;
        end
        2: begin
          rate = 16'hFFFF; min_gap = 16'd0; min_count = 16'hFFFF;
        end
        3: begin
          rate = 16'($urandom); min_gap = 16'($urandom);
          min_count = 16'($urandom_range(40));
        end
        4: begin
          rate = 16'd1; min_gap = 16'd1; min_count = 16'd1;
        end
        5: begin
          rate = 16'($urandom); min_gap = 16'($urandom_range(500));
          min_count = 16'($urandom_range(5, 20));
        end
        6: begin
          rate = 16'hFFFF; min_gap = 16'($urandom_range(4000)); min_count = 16'd3;
        end
        default: begin
          rate = 16'($urandom); min_gap = 16'($urandom);
          min_count = 16'($urandom_range(25));
        end
      endcase
      set_reg(REG_STEP_SIZE, rate);
      set_reg(REG_MIN_DIFFERENCE, min_gap);
      set_reg(REG_CHOICES_NEEDED, min_count);

      // two phases run back to back with no idling on either side
      send_gaps_on     = (p != 2 && p != 5);
      result_stalls_on = (p != 2 && p != 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // once, let the pipeline empty completely mid-stream
        if (p == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
        pick_factors(min_gap, a_vec, b_vec);
        push_request(pick_kind(), a_vec, b_vec);
      end
    end

    // ---- soak: largest step, no threshold, full-rate traffic ----
    // Even lanes always favor A, odd lanes always favor B, so the weights climb
    // and fall steadily; with choices_needed at its top the flag stays low.
    wait_drained();
    set_reg(REG_STEP_SIZE, 16'hFFFF);
    set_reg(REG_MIN_DIFFERENCE, 16'd0);
    set_reg(REG_CHOICES_NEEDED, 16'hFFFF);
    send_gaps_on     = 1'b0;
    result_stalls_on = 1'b0;
    push_request(KIND_CLEAR, '0, '0);
    for (int n = 0; n < SOAK_RECORDS; n++) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        a_vec[i] = {i[0], 15'($urandom)};
        b_vec[i] = {~i[0], 15'($urandom)};
      end
      push_request(KIND_RECORD, a_vec, b_vec);
    end
    send_gaps_on     = 1'b1;
    result_stalls_on = 1'b1;
    push_request(KIND_QUERY, max_vec, min_vec);
    push_request(KIND_QUERY, min_vec, max_vec);
    repeat (6) begin
      pick_factors(16'd0, a_vec, b_vec);
      push_request(KIND_QUERY, a_vec, b_vec);
    end
    push_request(KIND_CLEAR, max_vec, min_vec);
    push_request(KIND_QUERY, max_vec, min_vec);

    // ---- wind down and verdict ----
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
